>>> rtl/core/sin_pkg.sv
// Shared types and constants for the slice index normalizer.
// Used by sin_front, sin_div, sin_back and the top level; depends on nothing.
package sin_pkg;

   localparam int VAL_W   = 32;           // start, stop and step
   localparam int LEN_W   = 16;           // sequence length and element number
   localparam int BND_W   = LEN_W + 1;    // normalized bound, -1 .. length
   localparam int QUO_W   = LEN_W;        // divider dividend and quotient
   localparam int DIV_BITS   = 2;         // quotient bits retired per stage
   localparam int DIV_STAGES = QUO_W / DIV_BITS;

   localparam int REQ_DATA_W = 128;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 1;

   typedef struct packed {
      logic signed [VAL_W-1:0] start_value;
      logic                    start_omitted;
      logic signed [VAL_W-1:0] stop_value;
      logic                    stop_omitted;
      logic signed [VAL_W-1:0] step_value;
      logic                    step_omitted;
      logic [LEN_W-1:0]        sequence_length;
      logic [LEN_W-1:0]        element_number;
   } sin_req_type;

   // Per-request values that ride alongside the divider
   typedef struct packed {
      logic signed [BND_W-1:0] first_index;
      logic signed [BND_W-1:0] end_bound;
      logic                    neg;        // step below zero
      logic                    nonempty;   // nonzero step and bounds in order
      logic                    big;        // step magnitude above 16 bits
      logic [LEN_W-1:0]        element_number;
      logic [LEN_W-1:0]        offset;     // element_number * |step|, low bits
   } sin_side_type;

   typedef struct packed {
      logic signed [BND_W-1:0] first_index;
      logic signed [BND_W-1:0] end_bound;
      logic [LEN_W-1:0]        element_count;
      logic [LEN_W-1:0]        element_index;
      logic                    element_valid;
   } sin_rsp_type;

endpackage

>>> rtl/core/sin_front.sv
// Front end: bound normalization, then span, divisor setup and offset multiply.
// Two register stages with valid/ready; depends on sin_pkg.
module sin_front #(
   parameter int MAX_LENGTH = 65535
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  sin_pkg::sin_req_type    in_req,
   output logic                    out_valid,
   input  logic                    out_ready,
   output sin_pkg::sin_side_type   out_side,
   output logic [sin_pkg::QUO_W-1:0] out_dividend,
   output logic [sin_pkg::QUO_W-1:0] out_divisor
);
   import sin_pkg::*;

   function automatic logic signed [BND_W-1:0] norm_bound(
      input logic signed [VAL_W-1:0] v,
      input logic                    omitted,
      input logic signed [BND_W-1:0] dflt,
      input logic [LEN_W-1:0]        len,
      input logic                    neg
   );
      logic signed [VAL_W:0]   sum;
      logic signed [BND_W-1:0] len_s;
      logic signed [BND_W-1:0] res;
      len_s = $signed({1'b0, len});
      sum   = $signed({v[VAL_W-1], v}) + $signed({{(VAL_W-LEN_W){1'b0}}, len});
      if (omitted) begin
         res = dflt;
      end else if (v[VAL_W-1]) begin
         if (sum[VAL_W]) begin
            res = neg ? -BND_W'(1) : '0;
         end else begin
            res = sum[BND_W-1:0];
         end
      end else if ($unsigned(v) >= {{(VAL_W-LEN_W){1'b0}}, len}) begin
         res = neg ? len_s - BND_W'(1) : len_s;
      end else begin
         res = v[BND_W-1:0];
      end
      return res;
   endfunction

   // Stage 1 registers
   logic                    v1_ff;
   logic signed [BND_W-1:0] first1_ff, first1_in;
   logic signed [BND_W-1:0] last1_ff, last1_in;
   logic                    neg1_ff, neg1_in;
   logic                    zero1_ff, zero1_in;
   logic                    big1_ff, big1_in;
   logic [LEN_W-1:0]        mag1_ff, mag1_in;
   logic [LEN_W-1:0]        num1_ff;

   // Stage 2 registers
   logic                    v2_ff;
   sin_side_type            side2_ff, side2_in;
   logic [QUO_W-1:0]        dvd2_ff, dvd2_in;
   logic [QUO_W-1:0]        dvs2_ff, dvs2_in;

   logic                    rdy1, rdy2;

   logic signed [VAL_W-1:0] step_s;
   logic [VAL_W-1:0]        mag;
   logic [LEN_W-1:0]        len_c;
   logic signed [BND_W-1:0] len_s;
   logic signed [BND_W:0]   span;
   logic [2*LEN_W-1:0]      prod;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      step_s = in_req.step_omitted ? VAL_W'(1) : in_req.step_value;
      neg1_in  = step_s[VAL_W-1];
      zero1_in = (step_s == '0);
      mag      = neg1_in ? (~step_s + VAL_W'(1)) : step_s;
      big1_in  = |mag[VAL_W-1:LEN_W];
      mag1_in  = mag[LEN_W-1:0];
      len_c    = (VAL_W'(in_req.sequence_length) > VAL_W'(MAX_LENGTH)) ?
                 LEN_W'(MAX_LENGTH) : in_req.sequence_length;
      len_s    = $signed({1'b0, len_c});
      first1_in = norm_bound(in_req.start_value, in_req.start_omitted,
                             neg1_in ? len_s - BND_W'(1) : '0, len_c, neg1_in);
      last1_in  = norm_bound(in_req.stop_value, in_req.stop_omitted,
                             neg1_in ? -BND_W'(1) : len_s, len_c, neg1_in);
   end

   always_comb begin
      span = neg1_ff ? ($signed({first1_ff[BND_W-1], first1_ff})
                        - $signed({last1_ff[BND_W-1], last1_ff}))
                     : ($signed({last1_ff[BND_W-1], last1_ff})
                        - $signed({first1_ff[BND_W-1], first1_ff}));
      prod = num1_ff * mag1_ff;
      side2_in.first_index    = first1_ff;
      side2_in.end_bound      = last1_ff;
      side2_in.neg            = neg1_ff;
      side2_in.nonempty       = !zero1_ff && !span[BND_W] && (span != '0);
      side2_in.big            = big1_ff;
      side2_in.element_number = num1_ff;
      side2_in.offset         = prod[LEN_W-1:0];
      dvd2_in = QUO_W'(span - (BND_W+1)'(1));
      // any nonzero divisor does when the quotient is not used
      dvs2_in = (big1_ff || zero1_ff) ? QUO_W'(1) : mag1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         first1_ff <= first1_in;
         last1_ff  <= last1_in;
         neg1_ff   <= neg1_in;
         zero1_ff  <= zero1_in;
         big1_ff   <= big1_in;
         mag1_ff   <= mag1_in;
         num1_ff   <= in_req.element_number;
      end
      if (rdy2 && v1_ff) begin
         side2_ff <= side2_in;
         dvd2_ff  <= dvd2_in;
         dvs2_ff  <= dvs2_in;
      end
   end

   assign out_valid    = v2_ff;
   assign out_side     = side2_ff;
   assign out_dividend = dvd2_ff;
   assign out_divisor  = dvs2_ff;

endmodule

>>> rtl/core/sin_div.sv
// Pipelined restoring divider: DIV_BITS quotient bits per register stage.
// Carries the request's side values along; depends on sin_pkg.
module sin_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  sin_pkg::sin_side_type     in_side,
   input  logic [sin_pkg::QUO_W-1:0] in_dividend,
   input  logic [sin_pkg::QUO_W-1:0] in_divisor,
   output logic                      out_valid,
   input  logic                      out_ready,
   output sin_pkg::sin_side_type     out_side,
   output logic [sin_pkg::QUO_W-1:0] out_quotient
);
   import sin_pkg::*;

   logic [DIV_STAGES-1:0] valid_ff;
   sin_side_type          side_ff [DIV_STAGES];
   logic [QUO_W-1:0]      rem_ff  [DIV_STAGES];
   logic [QUO_W-1:0]      dvd_ff  [DIV_STAGES];
   logic [QUO_W-1:0]      dvs_ff  [DIV_STAGES];
   logic [QUO_W-1:0]      quo_ff  [DIV_STAGES];

   logic [DIV_STAGES:0]   rdy;
   logic [DIV_STAGES-1:0] src_valid;
   sin_side_type          src_side [DIV_STAGES];
   logic [QUO_W-1:0]      src_rem  [DIV_STAGES];
   logic [QUO_W-1:0]      src_dvd  [DIV_STAGES];
   logic [QUO_W-1:0]      src_dvs  [DIV_STAGES];
   logic [QUO_W-1:0]      src_quo  [DIV_STAGES];
   logic [QUO_W-1:0]      rem_in   [DIV_STAGES];
   logic [QUO_W-1:0]      dvd_in   [DIV_STAGES];
   logic [QUO_W-1:0]      quo_in   [DIV_STAGES];

   always_comb begin
      rdy[DIV_STAGES] = out_ready;
      for (int s = DIV_STAGES - 1; s >= 0; s--) begin
         rdy[s] = !valid_ff[s] || rdy[s+1];
      end
   end
   assign in_ready = rdy[0];

   always_comb begin
      src_valid[0] = in_valid;
      src_side[0]  = in_side;
      src_rem[0]   = '0;
      src_dvd[0]   = in_dividend;
      src_dvs[0]   = in_divisor;
      src_quo[0]   = '0;
      for (int s = 1; s < DIV_STAGES; s++) begin
         src_valid[s] = valid_ff[s-1];
         src_side[s]  = side_ff[s-1];
         src_rem[s]   = rem_ff[s-1];
         src_dvd[s]   = dvd_ff[s-1];
         src_dvs[s]   = dvs_ff[s-1];
         src_quo[s]   = quo_ff[s-1];
      end
   end

   // Shift in the next dividend bits, subtract where the remainder allows
   always_comb begin : div_step
      logic [QUO_W-1:0] r;
      logic [QUO_W-1:0] d;
      logic [QUO_W-1:0] q;
      logic [QUO_W:0]   t;
      for (int s = 0; s < DIV_STAGES; s++) begin
         r = src_rem[s];
         d = src_dvd[s];
         q = src_quo[s];
         for (int b = 0; b < DIV_BITS; b++) begin
            t = {r, d[QUO_W-1]};
            d = {d[QUO_W-2:0], 1'b0};
            if (t >= {1'b0, src_dvs[s]}) begin
               t = t - {1'b0, src_dvs[s]};
               q = {q[QUO_W-2:0], 1'b1};
            end else begin
               q = {q[QUO_W-2:0], 1'b0};
            end
            r = t[QUO_W-1:0];
         end
         rem_in[s] = r;
         dvd_in[s] = d;
         quo_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            if (rdy[s]) begin
               valid_ff[s] <= src_valid[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (rdy[s] && src_valid[s]) begin
            side_ff[s] <= src_side[s];
            rem_ff[s]  <= rem_in[s];
            dvd_ff[s]  <= dvd_in[s];
            dvs_ff[s]  <= src_dvs[s];
            quo_ff[s]  <= quo_in[s];
         end
      end
   end

   assign out_valid    = valid_ff[DIV_STAGES-1];
   assign out_side     = side_ff[DIV_STAGES-1];
   assign out_quotient = quo_ff[DIV_STAGES-1];

endmodule

>>> rtl/core/sin_back.sv
// Output stage: element count, element index and valid flag, held until taken.
// Depends on sin_pkg.
module sin_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  sin_pkg::sin_side_type     in_side,
   input  logic [sin_pkg::QUO_W-1:0] in_quotient,
   output logic                      out_valid,
   input  logic                      out_ready,
   output sin_pkg::sin_rsp_type      out_rsp
);
   import sin_pkg::*;

   logic         valid_ff;
   sin_rsp_type  rsp_ff, rsp_in;
   logic         rdy;
   logic [LEN_W-1:0] count;
   logic [LEN_W-1:0] base;
   logic             hit;

   assign rdy      = !valid_ff || out_ready;
   assign in_ready = rdy;

   always_comb begin
      if (!in_side.nonempty) begin
         count = '0;
      end else if (in_side.big) begin
         count = LEN_W'(1);
      end else begin
         count = in_quotient + LEN_W'(1);
      end
      hit  = in_side.element_number < count;
      base = in_side.first_index[LEN_W-1:0];
      rsp_in.first_index   = in_side.first_index;
      rsp_in.end_bound     = in_side.end_bound;
      rsp_in.element_count = count;
      rsp_in.element_valid = hit;
      if (!hit) begin
         rsp_in.element_index = '0;
      end else if (in_side.neg) begin
         rsp_in.element_index = base - in_side.offset;
      end else begin
         rsp_in.element_index = base + in_side.offset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (rdy) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

>>> rtl/core/slice_index_normalizer.sv
// Slice index normalizer top level: stream ports, front end, divider, output stage.
// Depends on sin_pkg, sin_front, sin_div and sin_back.
//
// Takes one slice request per clock while the response side keeps up, and returns
// one response per request, in order, through two front-end stages (bound
// normalization; span, divisor and offset multiply), an 8-stage divider that
// retires two quotient bits per stage for the element count, and the output
// register. Each stage holds its request on its own while downstream is stalled,
// so requests keep entering until the pipeline is full.
module slice_index_normalizer #(
   parameter int MAX_LENGTH = 65535
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] start_value, [63:32] stop_value, [95:64] step_value,
   // [111:96] sequence_length, [127:112] element_number
   input  logic [sin_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] start_omitted, [1] stop_omitted, [2] step_omitted
   input  logic [sin_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [16:0] first_index, [33:17] end_bound, [49:34] element_count,
   // [65:50] element_index, [71:66] zero
   output logic [sin_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] element_valid
   output logic [sin_pkg::RSP_USER_W-1:0]     rsp_tuser
);
   import sin_pkg::*;

   sin_req_type      req;
   sin_side_type     f_side, d_side;
   logic [QUO_W-1:0] f_dvd, f_dvs, d_quo;
   logic             f_valid, f_ready, d_valid, d_ready;
   sin_rsp_type      rsp;

   always_comb begin
      req.start_value     = req_tdata[31:0];
      req.stop_value      = req_tdata[63:32];
      req.step_value      = req_tdata[95:64];
      req.sequence_length = req_tdata[111:96];
      req.element_number  = req_tdata[127:112];
      req.start_omitted   = req_tuser[0];
      req.stop_omitted    = req_tuser[1];
      req.step_omitted    = req_tuser[2];
   end

   sin_front #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_req       (req),
      .out_valid    (f_valid),
      .out_ready    (f_ready),
      .out_side     (f_side),
      .out_dividend (f_dvd),
      .out_divisor  (f_dvs)
   );

   sin_div u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (f_valid),
      .in_ready     (f_ready),
      .in_side      (f_side),
      .in_dividend  (f_dvd),
      .in_divisor   (f_dvs),
      .out_valid    (d_valid),
      .out_ready    (d_ready),
      .out_side     (d_side),
      .out_quotient (d_quo)
   );

   sin_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (d_valid),
      .in_ready    (d_ready),
      .in_side     (d_side),
      .in_quotient (d_quo),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_rsp     (rsp)
   );

   assign rsp_tdata = {6'b0, rsp.element_index, rsp.element_count,
                       rsp.end_bound, rsp.first_index};
   assign rsp_tuser = rsp.element_valid;

endmodule

>>> rtl/core/sin_checker.sv
// Port-level checks for the slice index normalizer, bound to the top level.
// Depends only on the top level's ports.
module sin_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [71:0]  rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
   else $error("stalled response changed");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
   else $error("response valid right after reset");

   // an element outside the slice reports index zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[65:50] == 16'd0)
   else $error("invalid element with nonzero index");

   // an empty slice has no valid element
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[49:34] == 16'd0 |-> !rsp_tuser[0])
   else $error("valid element in empty slice");

   // a nonempty slice has distinct bounds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[49:34] != 16'd0 |-> rsp_tdata[16:0] != rsp_tdata[33:17])
   else $error("nonempty slice with equal bounds");

endmodule

bind slice_index_normalizer sin_checker u_sin_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> tb/slice_index_normalizer_tb.sv
// Self-checking bench for slice_index_normalizer: directed and random slice requests,
// each checked against a table row or a behavioral normalizer. Depends on sin_pkg.
`timescale 1ns / 1ps

module slice_index_normalizer_tb;
   import sin_pkg::*;

   localparam int    CYCLE_LIMIT = 200000;
   localparam int    DRAIN_CYCLES = 30;
   localparam int    RANDOM_REQUESTS = 1930;
   localparam int    HOLD_CYCLES = 200;
   localparam int    HOLD_AFTER = 400;           // responses seen before the long hold
   localparam longint SLICE_MAX_LENGTH = 65535;
   localparam logic signed [31:0] MOST_NEG_32 = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POS_32 = 32'sh7FFF_FFFF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   sin_rsp_type  pending_slices[$];
   sin_req_type  table_reqs[$];
   bit           table_typed[$];
   sin_rsp_type  table_rsps[$];
   int           failure_count = 0;
   int           responses_seen = 0;
   int           cycle_count = 0;
   int           hold_left = 0;
   bit           hold_done = 1'b0;
   bit           quiet_mode = 1'b0;

   slice_index_normalizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_failure(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      failure_count++;
   endtask

   function automatic longint clamp_bound(input longint v, input bit omitted,
                                          input longint dflt, input longint len,
                                          input bit neg);
      if (omitted)
         return dflt;
      if (v < 0) begin
         v = v + len;
         if (v < 0)
            v = neg ? -1 : 0;
      end else if (v >= len) begin
         v = neg ? len - 1 : len;
      end
      return v;
   endfunction

   function automatic sin_rsp_type normalize_slice(input sin_req_type r);
      longint      step_v, len_v, num_v, lo, hi, count, index;
      bit          neg;
      sin_rsp_type res;
      step_v = r.step_omitted ? 64'sd1 : longint'($signed(r.step_value));
      len_v  = longint'(r.sequence_length);
      if (len_v > SLICE_MAX_LENGTH)
         len_v = SLICE_MAX_LENGTH;
      num_v  = longint'(r.element_number);
      neg    = step_v < 0;
      lo = clamp_bound(longint'($signed(r.start_value)), r.start_omitted,
                       neg ? len_v - 1 : 0, len_v, neg);
      hi = clamp_bound(longint'($signed(r.stop_value)), r.stop_omitted,
                       neg ? -1 : len_v, len_v, neg);
      count = 0;
      if (step_v > 0 && hi > lo)
         count = (hi - lo - 1) / step_v + 1;
      else if (step_v < 0 && lo > hi)
         count = (lo - hi - 1) / (-step_v) + 1;
      index = (num_v < count) ? lo + num_v * step_v : 0;
      res.first_index   = lo[BND_W-1:0];
      res.end_bound     = hi[BND_W-1:0];
      res.element_count = count[LEN_W-1:0];
      res.element_index = index[LEN_W-1:0];
      res.element_valid = num_v < count;
      return res;
   endfunction

   function automatic sin_req_type slice_req(input logic signed [31:0] start_v,
                                             input bit start_o,
                                             input logic signed [31:0] stop_v,
                                             input bit stop_o,
                                             input logic signed [31:0] step_v,
                                             input bit step_o,
                                             input int len, input int num);
      sin_req_type r;
      r.start_value     = start_v;
      r.start_omitted   = start_o;
      r.stop_value      = stop_v;
      r.stop_omitted    = stop_o;
      r.step_value      = step_v;
      r.step_omitted    = step_o;
      r.sequence_length = len[LEN_W-1:0];
      r.element_number  = num[LEN_W-1:0];
      return r;
   endfunction

   function automatic sin_rsp_type slice_rsp(input int first, input int last,
                                             input int count, input int index,
                                             input bit valid);
      sin_rsp_type e;
      e.first_index   = first[BND_W-1:0];
      e.end_bound     = last[BND_W-1:0];
      e.element_count = count[LEN_W-1:0];
      e.element_index = index[LEN_W-1:0];
      e.element_valid = valid;
      return e;
   endfunction

   task automatic add_row(input sin_req_type r, input bit typed, input sin_rsp_type e);
      table_reqs.push_back(r);
      table_typed.push_back(typed);
      table_rsps.push_back(e);
   endtask

   function automatic logic signed [31:0] pick_bound(input int len);
      case ($urandom_range(7))
         0: return $urandom;
         1: return $urandom_range(1) ? MOST_NEG_32 : MOST_POS_32;
         default: return $urandom_range(0, 4 * len + 8) - (2 * len + 4);
      endcase
   endfunction

   function automatic logic signed [31:0] pick_step();
      case ($urandom_range(9))
         0: return $urandom;
         1: begin
            case ($urandom_range(3))
               0: return MOST_NEG_32;
               1: return MOST_POS_32;
               2: return 0;
               default: return -1;
            endcase
         end
         default: return $urandom_range(0, 10) - 5;
      endcase
   endfunction

   function automatic sin_req_type random_slice_req();
      int len, num;
      case ($urandom_range(9))
         0: len = $urandom_range(0, 65535);
         1: len = $urandom_range(1) ? 65535 : 0;
         default: len = $urandom_range(0, 40);
      endcase
      // mostly aim near the slice length so both valid and out-of-slice numbers occur
      num = ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, len + 2);
      return slice_req(pick_bound(len), $urandom_range(3) == 0,
                       pick_bound(len), $urandom_range(3) == 0,
                       pick_step(), $urandom_range(3) == 0, len, num);
   endfunction

   task automatic offer_slice(input sin_req_type r, input bit typed, input sin_rsp_type want);
      while (!quiet_mode && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r.element_number, r.sequence_length, r.step_value,
                     r.stop_value, r.start_value};
      req_tuser  <= {r.step_omitted, r.stop_omitted, r.start_omitted};
      do
         @(posedge clock);
      while (!req_tready);
      pending_slices.push_back(typed ? want : normalize_slice(r));
   endtask

   // Stimulus: directed table first, then random requests
   initial begin
      sin_rsp_type none;
      none = '0;
      // all bounds omitted, extremes of length and element number
      add_row(slice_req(0, 1, 0, 1, 0, 1, 0, 0), 1, slice_rsp(0, 0, 0, 0, 0));
      add_row(slice_req(0, 1, 0, 1, 0, 1, 65535, 65535), 1,
              slice_rsp(0, 65535, 65535, 0, 0));
      add_row(slice_req(0, 1, 0, 1, 0, 1, 65535, 0), 1, slice_rsp(0, 65535, 65535, 0, 1));
      // extreme bounds clamp at zero and at length
      add_row(slice_req(MOST_NEG_32, 0, MOST_POS_32, 0, 0, 1, 100, 99), 1,
              slice_rsp(0, 100, 100, 99, 1));
      // zero step selects nothing
      add_row(slice_req(0, 1, 0, 1, 0, 0, 50, 0), 1, slice_rsp(0, 50, 0, 0, 0));
      // negative step defaults
      add_row(slice_req(0, 1, 0, 1, -1, 0, 10, 0), 1, slice_rsp(9, -1, 10, 9, 1));
      // most negative and most positive step
      add_row(slice_req(0, 1, 0, 1, MOST_NEG_32, 0, 65535, 0), 1,
              slice_rsp(65534, -1, 1, 65534, 1));
      add_row(slice_req(0, 1, 0, 1, MOST_NEG_32, 0, 65535, 1), 1,
              slice_rsp(65534, -1, 1, 0, 0));
      add_row(slice_req(0, 0, 0, 1, MOST_POS_32, 0, 65535, 0), 1,
              slice_rsp(0, 65535, 1, 0, 1));
      // negative step, bounds out of range on both sides, then mixed bounds and steps
      add_row(slice_req(MOST_POS_32, 0, MOST_NEG_32, 0, -2, 0, 7, 3), 1,
              slice_rsp(6, -1, 4, 0, 1));
      add_row(slice_req(-3, 0, -1, 0, 0, 1, 10, 1), 1, slice_rsp(7, 9, 2, 8, 1));
      add_row(slice_req(1, 0, 20, 0, 3, 0, 15, 4), 0, none);
      add_row(slice_req(0, 1, 2, 0, -3, 0, 20, 5), 0, none);
      add_row(slice_req(8, 0, 3, 0, 1, 0, 10, 0), 0, none);
      add_row(slice_req(0, 1, 0, 1, -1, 0, 0, 0), 0, none);
      add_row(slice_req(65535, 0, 0, 1, 0, 1, 65535, 0), 0, none);
      add_row(slice_req(-65535, 0, 0, 1, -1, 0, 65535, 0), 0, none);
      add_row(slice_req(MOST_NEG_32, 0, 5, 0, -5, 0, 12, 0), 0, none);
      // step value ignored when step is omitted, then large bounds and lengths
      add_row(slice_req(2, 0, 9, 0, 0, 1, 12, 6), 0, none);
      add_row(slice_req(40000, 0, 3, 0, MOST_NEG_32, 0, 50000, 0), 0, none);
      add_row(slice_req(0, 0, 65535, 0, 1, 0, 65535, 65534), 0, none);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_reqs[i])
         offer_slice(table_reqs[i], table_typed[i], table_rsps[i]);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         quiet_mode = (n >= 900 && n < 1200);
         offer_slice(random_slice_req(), 1'b0, none);
      end
      quiet_mode = 1'b0;
      req_tvalid <= 1'b0;

      while (pending_slices.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failure_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Response check and response-side backpressure
   always @(posedge clock) begin : check_slices
      sin_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_slices.size() == 0) begin
               report_failure("response with no request outstanding");
            end else begin
               want = pending_slices.pop_front();
               if (rsp_tdata[16:0] !== want.first_index)
                  report_failure($sformatf("first_index got %h want %h",
                                           rsp_tdata[16:0], want.first_index));
               if (rsp_tdata[33:17] !== want.end_bound)
                  report_failure($sformatf("end_bound got %h want %h",
                                           rsp_tdata[33:17], want.end_bound));
               if (rsp_tdata[49:34] !== want.element_count)
                  report_failure($sformatf("element_count got %h want %h",
                                           rsp_tdata[49:34], want.element_count));
               if (rsp_tdata[65:50] !== want.element_index)
                  report_failure($sformatf("element_index got %h want %h",
                                           rsp_tdata[65:50], want.element_index));
               if (rsp_tuser[0] !== want.element_valid)
                  report_failure($sformatf("element_valid got %b want %b",
                                           rsp_tuser[0], want.element_valid));
            end
            responses_seen++;
         end
         // hold off once long enough to fill the pipeline and stall requests
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && responses_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet_mode || ($urandom_range(99) >= 20);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule

>>> filelist.f
rtl/core/sin_pkg.sv
rtl/core/sin_front.sv
rtl/core/sin_div.sv
rtl/core/sin_back.sv
rtl/core/slice_index_normalizer.sv
rtl/core/sin_checker.sv
tb/slice_index_normalizer_tb.sv
